### rtl/core/padded_radix_number_formatter_defines.svh
// Assertion macros for the formatter RTL.
`ifndef PADDED_RADIX_NUMBER_FORMATTER_DEFINES_SVH
`define PADDED_RADIX_NUMBER_FORMATTER_DEFINES_SVH

// Same-cycle implication.
`define PRNF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define PRNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/core/prnf_pkg.sv
`default_nettype none

package prnf_pkg;

  localparam int MAX_WIDTH     = 40;
  localparam int WIDTH_W       = 6;
  localparam int VALUE_W       = 64;
  localparam int BCD_DIGITS    = 20;
  localparam int BCD_W         = BCD_DIGITS * 4;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int CNT_W         = $clog2(CONV_STEPS);
  localparam int DN_W          = $clog2(BCD_DIGITS + 1);
  localparam int IDX_W         = $clog2(BCD_DIGITS);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEXL = 3'd2,
    KIND_HEXU = 3'd3,
    KIND_PTR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    SEL_ZERO  = 3'd0,
    SEL_X     = 3'd1,
    SEL_SPACE = 3'd2,
    SEL_SIGN  = 3'd3,
    SEL_DIGIT = 3'd4
  } ch_sel_e;

  typedef struct packed {
    logic    load;
    logic    conv_step;
    logic    size;
    logic    pad_dec;
    logic    idx_dec;
    ch_sel_e sel;
  } prnf_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic has_prefix;
    logic has_sign;
    logic left;
    logic zero;
    logic pad_nz;
    logic pad_one;
    logic idx_zero;
  } prnf_sts_t;

  function automatic logic is_hex_kind(input logic [2:0] kind);
    logic hex;
    hex = (kind == KIND_HEXL) || (kind == KIND_HEXU) || (kind == KIND_PTR);
    return hex;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + 8'(nib);
    end else begin
      c = (upper ? CH_UP_A : CH_LO_A) + 8'(nib) - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/padded_radix_number_formatter.sv
// Formats one 64-bit value per transfer as signed decimal, unsigned decimal,
// lower or upper hex, or pointer text, and sends it out one ASCII character
// per transfer, most significant first, with last set on the final one.
// Padding to min_width (saturated at 40) follows the usual printf rules; a
// pointer's "0x" is not counted in the width. One item is worked at a time:
// a decimal item is taken in the idle state, goes through the binary-to-BCD
// converter (four bits per cycle), then a sizing state and a routing state,
// and then sends its characters; hex items skip the converter, and pointer
// items also skip the routing state. Codes 5 to 7 format as unsigned decimal.
// The input is stalled until the last character of the current item has
// been transferred.
`default_nettype none

module padded_radix_number_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [63:0] value_i,
  input  wire logic [5:0]  min_width_i,
  input  wire logic        zfill_i,
  input  wire logic        ljust_i,
  input  wire logic        plus_sign_i,
  input  wire logic        space_sign_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       ch_o,
  output logic             last_o
);
  import prnf_pkg::*;

  prnf_cmd_t cmd;
  prnf_sts_t sts;

  prnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .last_o      (last_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  prnf_datapath u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (cmd_i),
    .value_i      (value_i),
    .min_width_i  (min_width_i),
    .zfill_i      (zfill_i),
    .ljust_i      (ljust_i),
    .plus_sign_i  (plus_sign_i),
    .space_sign_i (space_sign_i),
    .ch_o         (ch_o)
  );

endmodule

`default_nettype wire

### rtl/core/prnf_datapath.sv
`default_nettype none

module prnf_datapath (
  input  wire logic                clk_i,
  input  wire prnf_pkg::prnf_cmd_t cmd_i,
  output prnf_pkg::prnf_sts_t      sts_o,
  input  wire logic [2:0]          kind_i,
  input  wire logic [63:0]         value_i,
  input  wire logic [5:0]          min_width_i,
  input  wire logic                zfill_i,
  input  wire logic                ljust_i,
  input  wire logic                plus_sign_i,
  input  wire logic                space_sign_i,
  output logic [7:0]               ch_o
);
  import prnf_pkg::*;

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [WIDTH_W-1:0] width_q;
  logic [WIDTH_W-1:0] pad_q;
  logic [IDX_W-1:0]   idx_q;
  logic [7:0]         sign_ch_q;
  logic               has_sign_q;
  logic               upper_q;
  logic               prefix_q;
  logic               left_q;
  logic               zero_q;

  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [WIDTH_W-1:0] width_sat;
  logic [DN_W-1:0]    dn;
  logic [WIDTH_W-1:0] total;
  logic [WIDTH_W-1:0] pad_new;

  assign neg       = (kind_i == KIND_SDEC) && value_i[VALUE_W-1];
  assign mag       = neg ? (~value_i + 64'd1) : value_i;
  assign width_sat = (min_width_i > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : min_width_i;

  always_comb begin
    bcd_d = bcd_q;
    bin_d = bin_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (bcd_d[d*4 +: 4] >= 4'd5) begin
          bcd_d[d*4 +: 4] = bcd_d[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_d, bin_d} = {bcd_d[BCD_W-2:0], bin_d, 1'b0};
    end
  end

  always_comb begin
    dn = DN_W'(1);
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        dn = DN_W'(i + 1);
      end
    end
    total   = WIDTH_W'(dn) + WIDTH_W'(has_sign_q);
    pad_new = (width_q > total) ? (width_q - total) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q      <= mag;
      bcd_q      <= is_hex_kind(kind_i) ? BCD_W'(value_i) : '0;
      cnt_q      <= '0;
      width_q    <= width_sat;
      has_sign_q <= neg || ((kind_i == KIND_SDEC) && (plus_sign_i || space_sign_i));
      sign_ch_q  <= neg ? CH_MINUS : (plus_sign_i ? CH_PLUS : CH_SPACE);
      upper_q    <= (kind_i == KIND_HEXU);
      prefix_q   <= (kind_i == KIND_PTR);
      left_q     <= ljust_i;
      zero_q     <= zfill_i;
    end
    if (cmd_i.conv_step) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.size) begin
      pad_q <= pad_new;
      idx_q <= IDX_W'(dn - DN_W'(1));
    end
    if (cmd_i.pad_dec) begin
      pad_q <= pad_q - WIDTH_W'(1);
    end
    if (cmd_i.idx_dec) begin
      idx_q <= idx_q - IDX_W'(1);
    end
  end

  always_comb begin
    sts_o.conv_last  = (cnt_q == CNT_W'(CONV_STEPS - 1));
    sts_o.has_prefix = prefix_q;
    sts_o.has_sign   = has_sign_q;
    sts_o.left       = left_q;
    sts_o.zero       = zero_q;
    sts_o.pad_nz     = (pad_q != '0);
    sts_o.pad_one    = (pad_q == WIDTH_W'(1));
    sts_o.idx_zero   = (idx_q == '0);
  end

  always_comb begin
    unique case (cmd_i.sel)
      SEL_ZERO:  ch_o = CH_ZERO;
      SEL_X:     ch_o = CH_X;
      SEL_SPACE: ch_o = CH_SPACE;
      SEL_SIGN:  ch_o = sign_ch_q;
      SEL_DIGIT: ch_o = digit_char(bcd_q[{idx_q, 2'b00} +: 4], upper_q);
      default:   ch_o = CH_SPACE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/prnf_ctrl.sv
`default_nettype none

`include "padded_radix_number_formatter_defines.svh"

module prnf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          kind_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     last_o,
  output prnf_pkg::prnf_cmd_t      cmd_o,
  input  wire prnf_pkg::prnf_sts_t sts_i
);
  import prnf_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CONV  = 11'b000_0000_0010,
    ST_SIZE  = 11'b000_0000_0100,
    ST_ROUTE = 11'b000_0000_1000,
    ST_PFX0  = 11'b000_0001_0000,
    ST_PFXX  = 11'b000_0010_0000,
    ST_PADL  = 11'b000_0100_0000,
    ST_SIGN  = 11'b000_1000_0000,
    ST_ZPAD  = 11'b001_0000_0000,
    ST_DIGIT = 11'b010_0000_0000,
    ST_PADR  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  function automatic state_e route_next(input prnf_sts_t s);
    state_e n;
    if (!s.left && !s.zero && s.pad_nz) begin
      n = ST_PADL;
    end else if (s.has_sign) begin
      n = ST_SIGN;
    end else if (!s.left && s.zero && s.pad_nz) begin
      n = ST_ZPAD;
    end else begin
      n = ST_DIGIT;
    end
    return n;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign fire       = out_valid_o && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.sel   = SEL_SPACE;
    out_valid_o = 1'b0;
    last_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = is_hex_kind(kind_i) ? ST_SIZE : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_last) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = sts_i.has_prefix ? ST_PFX0 : ST_ROUTE;
      end
      ST_ROUTE: begin
        state_d = route_next(sts_i);
      end
      ST_PFX0: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_ZERO;
        if (fire) begin
          state_d = ST_PFXX;
        end
      end
      ST_PFXX: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_X;
        if (fire) begin
          state_d = route_next(sts_i);
        end
      end
      ST_PADL: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_SPACE;
        if (fire) begin
          cmd_o.pad_dec = 1'b1;
          if (sts_i.pad_one) begin
            state_d = sts_i.has_sign ? ST_SIGN : ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_SIGN;
        if (fire) begin
          state_d = (!sts_i.left && sts_i.zero && sts_i.pad_nz) ? ST_ZPAD : ST_DIGIT;
        end
      end
      ST_ZPAD: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_ZERO;
        if (fire) begin
          cmd_o.pad_dec = 1'b1;
          if (sts_i.pad_one) begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_DIGIT;
        last_o      = sts_i.idx_zero && !(sts_i.left && sts_i.pad_nz);
        if (fire) begin
          if (sts_i.idx_zero) begin
            state_d = (sts_i.left && sts_i.pad_nz) ? ST_PADR : ST_IDLE;
          end else begin
            cmd_o.idx_dec = 1'b1;
          end
        end
      end
      ST_PADR: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_SPACE;
        last_o      = sts_i.pad_one;
        if (fire) begin
          cmd_o.pad_dec = 1'b1;
          if (sts_i.pad_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PRNF_ASSERT_NEXT(a_accept_starts_work, clk_i, rst_ni, in_valid_i && !in_stall_o, (state_q == ST_CONV) || (state_q == ST_SIZE))
  `PRNF_ASSERT_NOW(a_no_accept_while_emitting, clk_i, rst_ni, out_valid_o, in_stall_o)
  `PRNF_ASSERT_NEXT(a_last_ends_item, clk_i, rst_ni, fire && last_o, state_q == ST_IDLE)

endmodule

`default_nettype wire

### dv/tb_padded_radix_number_formatter.sv
`timescale 1ns / 1ps

module tb_padded_radix_number_formatter;
  import prnf_pkg::*;

  localparam int RANDOM_ITEMS = 354;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_XFER = 150;
  localparam int PAUSE_AT_ITEM = 250;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
    logic [5:0]  min_width;
    logic        zfill;
    logic        ljust;
    logic        plus_sign;
    logic        space_sign;
  } fmt_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  typedef struct {
    fmt_item_t it;
    string     text;
  } text_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [63:0] value_i = '0;
  logic [5:0]  min_width_i = '0;
  logic        zfill_i = 1'b0;
  logic        ljust_i = 1'b0;
  logic        plus_sign_i = 1'b0;
  logic        space_sign_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  ch_o;
  logic        last_o;

  text_char_t  chars_due_q[$];
  text_row_t   text_rows[$];
  int          errors = 0;
  int          items_sent = 0;
  int          chars_seen = 0;
  int          cycles = 0;

  padded_radix_number_formatter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .min_width_i (min_width_i),
    .zfill_i     (zfill_i),
    .ljust_i     (ljust_i),
    .plus_sign_i (plus_sign_i),
    .space_sign_i(space_sign_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ch_o        (ch_o),
    .last_o      (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void queue_chars(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) begin
      chars_due_q.push_back('{ch: txt[i], last: (i == txt.size() - 1)});
    end
  endfunction

  function automatic void format_number(input fmt_item_t it);
    logic [63:0] mag;
    logic [63:0] base;
    logic        upper;
    logic        prefix;
    logic        has_sign;
    logic [7:0]  sign_ch;
    logic [7:0]  rev[24];
    logic [7:0]  txt[$];
    logic [3:0]  nib;
    int          dn;
    int          width;
    int          pad;
    mag = it.value;
    base = 64'd10;
    upper = 1'b0;
    prefix = 1'b0;
    has_sign = 1'b0;
    sign_ch = CH_SPACE;
    dn = 0;
    width = (it.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(it.min_width);
    case (it.cmd)
      KIND_SDEC: begin
        if (mag[63]) begin
          has_sign = 1'b1;
          sign_ch = CH_MINUS;
          mag = ~mag + 64'd1;
        end else if (it.plus_sign) begin
          has_sign = 1'b1;
          sign_ch = CH_PLUS;
        end else if (it.space_sign) begin
          has_sign = 1'b1;
          sign_ch = CH_SPACE;
        end
      end
      KIND_HEXL: base = 64'd16;
      KIND_HEXU: begin
        base = 64'd16;
        upper = 1'b1;
      end
      KIND_PTR: begin
        base = 64'd16;
        prefix = 1'b1;
      end
      default: ;
    endcase
    do begin
      nib = 4'(mag % base);
      rev[dn] = (nib < 4'd10) ? CH_ZERO + 8'(nib) : (upper ? CH_UP_A : CH_LO_A) + 8'(nib) - 8'd10;
      mag = mag / base;
      dn++;
    end while (mag != 64'd0);
    pad = width - (dn + int'(has_sign));
    if (pad < 0) pad = 0;
    if (prefix) begin
      txt.push_back(CH_ZERO);
      txt.push_back(CH_X);
    end
    if (!it.ljust && !it.zfill) for (int i = 0; i < pad; i++) txt.push_back(CH_SPACE);
    if (has_sign) txt.push_back(sign_ch);
    if (!it.ljust && it.zfill) for (int i = 0; i < pad; i++) txt.push_back(CH_ZERO);
    for (int i = dn - 1; i >= 0; i--) txt.push_back(rev[i]);
    if (it.ljust) for (int i = 0; i < pad; i++) txt.push_back(CH_SPACE);
    queue_chars(txt);
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [63:0] value,
                                  input logic [5:0] w, input logic zp, input logic la,
                                  input logic ps, input logic ss, input string text);
    text_row_t r;
    r.it = '{cmd: cmd, value: value, min_width: w, zfill: zp, ljust: la,
             plus_sign: ps, space_sign: ss};
    r.text = text;
    text_rows.push_back(r);
  endfunction

  function automatic fmt_item_t random_item();
    fmt_item_t it;
    int        shape;
    it.cmd = ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 4))
                                          : 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    shape = $urandom_range(0, 7);
    case (shape)
      0: it.value = {$urandom, $urandom};
      1: it.value = 64'($urandom_range(0, 999));
      2: it.value = -64'($urandom_range(1, 999));
      3: it.value = 64'd1 << $urandom_range(0, 63);
      4: it.value = {64{1'b1}} >> $urandom_range(0, 63);
      5: it.value = $urandom_range(0, 1) ? {1'b1, 63'd0} : 64'd0;
      default: it.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    it.min_width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 24));
    it.zfill = 1'($urandom_range(0, 1));
    it.ljust = 1'($urandom_range(0, 1));
    it.plus_sign = 1'($urandom_range(0, 1));
    it.space_sign = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic offer(input fmt_item_t it, input string text, input int gap);
    logic [7:0] txt[$];
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i        <= it.cmd;
    value_i      <= it.value;
    min_width_i  <= it.min_width;
    zfill_i      <= it.zfill;
    ljust_i      <= it.ljust;
    plus_sign_i  <= it.plus_sign;
    space_sign_i <= it.space_sign;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (text.len() > 0) begin
      for (int i = 0; i < text.len(); i++) txt.push_back(text[i]);
      queue_chars(txt);
    end else begin
      format_number(it);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Check each output transfer against the oldest expected character.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_seen++;
      if (chars_due_q.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual ch=%h last=%b",
                 $time, ch_o, last_o);
        errors++;
      end else begin
        want = chars_due_q.pop_front();
        if (want.ch !== ch_o) begin
          $display("%0t: ch mismatch: expected %h, actual %h", $time, want.ch, ch_o);
          errors++;
        end
        if (want.last !== last_o) begin
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  // Output side: random stall per transfer, quiet stretches, one long hold.
  initial begin
    int n;
    int xfers;
    xfers = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      n = (((xfers / 500) % 3) == 1) ? 0 : $urandom_range(0, 14);
      if (xfers == HOLD_AT_XFER) n = LONG_HOLD;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      xfers++;
      @(negedge clk_i);
    end
  end

  initial begin
    int gap;
    add_row(KIND_SDEC, 64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, "0");
    add_row(KIND_SDEC, {1'b1, 63'd0}, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, "-9223372036854775808");
    add_row(KIND_SDEC, {1'b0, {63{1'b1}}}, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0,
            "+9223372036854775807");
    add_row(KIND_UDEC, {64{1'b1}}, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, "18446744073709551615");
    add_row(KIND_HEXL, {64{1'b1}}, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, "ffffffffffffffff");
    add_row(KIND_HEXL, 64'h0123456789abcdef, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, "123456789abcdef");
    add_row(KIND_HEXU, 64'hdeadbeef, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, "DEADBEEF");
    add_row(KIND_PTR, 64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, "0x0");
    add_row(KIND_SDEC, 64'd42, 6'd5, 1'b0, 1'b0, 1'b1, 1'b0, "  +42");
    add_row(KIND_SDEC, 64'd42, 6'd5, 1'b0, 1'b0, 1'b0, 1'b1, "   42");
    add_row(KIND_SDEC, 64'd0, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, "+0");
    add_row(KIND_SDEC, 64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, " 0");
    add_row(KIND_SDEC, -64'd5, 6'd4, 1'b1, 1'b0, 1'b0, 1'b0, "-005");
    add_row(KIND_SDEC, -64'd5, 6'd4, 1'b0, 1'b1, 1'b0, 1'b0, "-5  ");
    add_row(KIND_UDEC, 64'd7, 6'd3, 1'b1, 1'b1, 1'b0, 1'b0, "7  ");
    add_row(KIND_UDEC, 64'd5, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, "5");
    add_row(KIND_UDEC, 64'd0, 6'd1, 1'b0, 1'b0, 1'b0, 1'b0, "0");
    add_row(KIND_HEXL, 64'd255, 6'd6, 1'b1, 1'b0, 1'b0, 1'b0, "0000ff");
    add_row(KIND_PTR, 64'd255, 6'd6, 1'b0, 1'b0, 1'b0, 1'b0, "0x    ff");
    add_row(KIND_PTR, 64'd255, 6'd6, 1'b1, 1'b0, 1'b1, 1'b1, "0x0000ff");
    add_row(KIND_SPARE_LO, 64'd123, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0, "123");
    add_row(KIND_SPARE_HI, 64'd0, 6'd63, 1'b1, 1'b0, 1'b0, 1'b0, "");
    add_row(KIND_SDEC, 64'd1, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0, "");
    add_row(KIND_SDEC, {64{1'b1}}, 6'd40, 1'b1, 1'b0, 1'b1, 1'b0, "");
    add_row(KIND_PTR, {64{1'b1}}, 6'd40, 1'b0, 1'b1, 1'b0, 1'b0, "");
    add_row(KIND_HEXU, 64'd1, 6'd41, 1'b1, 1'b0, 1'b0, 1'b0, "");

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (text_rows[i]) begin
      offer(text_rows[i].it, text_rows[i].text, $urandom_range(0, 14));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT_ITEM) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (chars_due_q.size() != 0) @(negedge clk_i);
      end
      gap = (i >= 100 && i < 160) ? 0 : $urandom_range(0, 14);
      offer(random_item(), "", gap);
    end
    in_valid_i <= 1'b0;

    while (chars_due_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Formatted %0d items (%0d directed) into %0d characters,", items_sent,
             text_rows.size(), chars_seen);
    $display("all kinds, widths up to 63, pad/sign flags, long output hold and input pause.");
    if (errors == 0 && chars_due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
